[hw/rtl/blhs_pkg.sv]
// shared constants, keyword tables and helpers for the basic line header scanner
package blhs_pkg;

  localparam int unsigned TOKEN_MAX_DEF = 16;
  localparam int unsigned NUM_KW        = 15;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;

  localparam logic [3:0] CODE_UNKNOWN = 4'd15;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNKNOWN_KW  = 2'd1,
    ST_NO_NUMBER   = 2'd2,
    ST_NO_SPACE    = 2'd3
  } status_e;

  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"R", "E", "M", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "R", "I", "N", "T", 8'h00, 8'h00, 8'h00},
    '{"D", "I", "M", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "N", "P", "U", "T", 8'h00, 8'h00, 8'h00},
    '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "A", "T", "A", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "N", "T", "E", "R", 8'h00, 8'h00, 8'h00},
    '{"G", "O", "S", "U", "B", 8'h00, 8'h00, 8'h00},
    '{"G", "O", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "E", "S", "T", "O", "R", "E", 8'h00},
    '{"R", "E", "T", "U", "R", "N", 8'h00, 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd3, 3'd5, 3'd2, 3'd3, 3'd3, 3'd4,
    3'd5, 3'd5, 3'd4, 3'd4, 3'd7, 3'd6, 3'd4
  };

  typedef struct packed {
    logic [3:0] code;
    logic [1:0] status;
  } verdict_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  // first surviving keyword in list order
  function automatic verdict_t first_kw(input logic [NUM_KW-1:0] cand);
    verdict_t v;
    v.code   = CODE_UNKNOWN;
    v.status = ST_UNKNOWN_KW;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k]) begin
        v.code   = 4'(k);
        v.status = ST_OK;
      end
    end
    return v;
  endfunction

endpackage

[hw/rtl/blhs_kw_match.sv]
// per-character keyword candidate filter
module blhs_kw_match import blhs_pkg::*; #(
  parameter int unsigned TOKEN_MAX = TOKEN_MAX_DEF,
  localparam int unsigned LenW = $clog2(TOKEN_MAX + 1)
) (
  input  logic [NUM_KW-1:0] cand_i,
  input  logic [LenW-1:0]   token_len_i,
  input  logic [7:0]        char_i,
  output logic [NUM_KW-1:0] cand_o
);

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cand_o[k] = cand_i[k] && (token_len_i < LenW'(KW_LEN[k])) &&
                  (KW_TEXT[k][token_len_i[2:0]] == char_i);
    end
  end

endmodule

[hw/rtl/basic_line_header_scanner_top.sv]
// basic line header scanner: byte stream in, at most one header result per line out
//
//  channel  | dir | tdata                                   | tlast
//  s_axis   | in  | [7:0] text_byte                         | end_of_text
//  m_axis   | out | [31:0] line_number [35:32] command_code | -
//           |     | [37:36] status [39:38] zero             |
//
// one byte per cycle unless a held result stalls the input; a byte goes from the input
// register through the scan step into the result register
// the scan phase, number, candidate, length and halt registers form the scan loop
// reset clears the scan state, the halt flag and both valid flags
// a held result stalls the input register only when a new byte is waiting
module basic_line_header_scanner_top import blhs_pkg::*; #(
  parameter int unsigned TOKEN_MAX = TOKEN_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // line_number, command_code, status, pad
);

  localparam int unsigned LenW = $clog2(TOKEN_MAX + 1);

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_NUMBER,
    PH_GAP,
    PH_TOKEN,
    PH_SKIP
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [31:0]         acc_q, acc_d;
  logic [NUM_KW-1:0]   cand_q, cand_d;
  logic [LenW-1:0]     len_q, len_d;
  logic                halt_q, halt_d;

  logic                in_vld_q;
  logic [7:0]          in_byte_q;
  logic                in_eot_q;

  logic                out_vld_q;
  logic [31:0]         out_num_q, out_num_d;
  logic [3:0]          out_code_q, out_code_d;
  logic [1:0]          out_stat_q, out_stat_d;

  logic                advance;
  logic                emit;
  logic [NUM_KW-1:0]   cand_add;
  verdict_t            fin_cur, fin_add, fin_nxt;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  blhs_kw_match #(
    .TOKEN_MAX(TOKEN_MAX)
  ) u_kw_match (
    .cand_i     (cand_q),
    .token_len_i(len_q),
    .char_i     (in_byte_q),
    .cand_o     (cand_add)
  );

  assign fin_cur = first_kw(cand_q);
  assign fin_add = first_kw(cand_add);

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cand_d     = cand_q;
    len_d      = len_q;
    halt_d     = halt_q;
    emit       = 1'b0;
    fin_nxt    = fin_cur;
    out_num_d  = acc_q;
    out_code_d = CODE_UNKNOWN;
    out_stat_d = ST_OK;
    if (!halt_q) begin
      unique case (phase_q) inside
        PH_LINE_START: begin
          if (is_digit(in_byte_q)) begin
            acc_d   = {24'd0, in_byte_q - CH_ZERO};
            cand_d  = '1;
            len_d   = '0;
            phase_d = PH_NUMBER;
          end else if (!is_space(in_byte_q)) begin
            emit       = 1'b1;
            halt_d     = 1'b1;
            out_num_d  = '0;
            out_stat_d = ST_NO_NUMBER;
          end
        end
        PH_NUMBER: begin
          if (is_digit(in_byte_q)) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + {24'd0, in_byte_q - CH_ZERO};
          end else if (is_blank(in_byte_q)) begin
            phase_d = PH_GAP;
          end else begin
            emit       = 1'b1;
            halt_d     = 1'b1;
            out_stat_d = ST_NO_SPACE;
          end
        end
        PH_GAP, PH_TOKEN: begin
          if (phase_q == PH_GAP && is_blank(in_byte_q)) begin
            phase_d = PH_GAP;
          end else if (is_space(in_byte_q)) begin
            emit       = 1'b1;
            out_code_d = fin_cur.code;
            out_stat_d = fin_cur.status;
            if (in_byte_q == CH_LF) begin
              phase_d = PH_LINE_START;
              acc_d   = '0;
              cand_d  = '1;
              len_d   = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end else begin
            cand_d  = cand_add;
            len_d   = len_q + LenW'(1);
            phase_d = PH_TOKEN;
            if (len_q == LenW'(TOKEN_MAX - 1)) begin
              emit       = 1'b1;
              out_code_d = fin_add.code;
              out_stat_d = fin_add.status;
              phase_d    = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (in_byte_q == CH_LF) begin
            phase_d = PH_LINE_START;
            acc_d   = '0;
            cand_d  = '1;
            len_d   = '0;
          end
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase

      fin_nxt = first_kw(cand_d);

      if (in_eot_q && !halt_d) begin
        if (!emit && phase_d == PH_NUMBER) begin
          emit       = 1'b1;
          halt_d     = 1'b1;
          out_num_d  = acc_d;
          out_code_d = CODE_UNKNOWN;
          out_stat_d = ST_NO_SPACE;
        end else begin
          if (!emit && (phase_d == PH_GAP || phase_d == PH_TOKEN)) begin
            emit       = 1'b1;
            out_num_d  = acc_d;
            out_code_d = fin_nxt.code;
            out_stat_d = fin_nxt.status;
          end
          phase_d = PH_LINE_START;
          acc_d   = '0;
          cand_d  = '1;
          len_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LINE_START;
      acc_q      <= '0;
      cand_q     <= '1;
      len_q      <= '0;
      halt_q     <= 1'b0;
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      out_num_q  <= '0;
      out_code_q <= '0;
      out_stat_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        phase_q   <= phase_d;
        acc_q     <= acc_d;
        cand_q    <= cand_d;
        len_q     <= len_d;
        halt_q    <= halt_d;
        out_vld_q <= emit;
        if (emit) begin
          out_num_q  <= out_num_d;
          out_code_q <= out_code_d;
          out_stat_q <= out_stat_d;
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_stat_q, out_code_q, out_num_q};

endmodule
